/* design/sesb_pkg.sv */
// Shared types, constants and arithmetic helpers for the solid element stiffness block.
// Used by the front end, the command queue and the compute engine.
package sesb_pkg;

    // Input item kinds carried in tuser
    localparam logic [1:0] FUNC_LOAD_C    = 2'd0;
    localparam logic [1:0] FUNC_LOAD_NODE = 2'd1;
    localparam logic [1:0] FUNC_PAIR      = 2'd2;

    // Configuration register indexes
    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_NODES = 1'b1;

    localparam int C_ENTRIES = 36;
    localparam int CVAL_ENTRIES = 18;

    typedef logic signed [47:0] acc_t;

    localparam acc_t ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam acc_t ACC_MIN = 48'sh8000_0000_0000;

    // Classified command as it travels through the queue
    typedef enum logic [1:0] {
        CMD_LOAD_C    = 2'd0,
        CMD_LOAD_NODE = 2'd1,
        CMD_PAIR      = 2'd2,
        CMD_BAD       = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [5:0]  slot;
        logic [4:0]  row;
        logic [31:0] value_a;
        logic [31:0] value_b;
        logic [31:0] value_c;
        logic [6:0]  dof_x;
        logic [6:0]  dof_y;
        logic [6:0]  dof_z;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_item_t;

    // Strain component of a (row axis, column axis) pair: order 11,22,33,12,23,13
    function automatic logic [2:0] strain_of(input logic [1:0] r, input logic [1:0] c);
        logic [2:0] s;
        case ({r, c})
            4'h0:    s = 3'd0;
            4'h1:    s = 3'd3;
            4'h2:    s = 3'd5;
            4'h4:    s = 3'd3;
            4'h5:    s = 3'd1;
            4'h6:    s = 3'd4;
            4'h8:    s = 3'd5;
            4'h9:    s = 3'd4;
            4'hA:    s = 3'd2;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    // Result order xx,yy,zz,xy,yx,xz,zx,yz,zy: row axis
    function automatic logic [1:0] pair_row(input logic [3:0] n);
        logic [1:0] r;
        case (n)
            4'd0, 4'd3, 4'd5: r = 2'd0;
            4'd1, 4'd4, 4'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    // Result order: column axis
    function automatic logic [1:0] pair_col(input logic [3:0] n);
        logic [1:0] c;
        case (n)
            4'd0, 4'd4, 4'd6: c = 2'd0;
            4'd1, 4'd3, 4'd8: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    // Clamp a wide signed value to 48-bit signed
    function automatic acc_t sat48(input logic signed [79:0] x);
        acc_t r;
        if (x > 80'(ACC_MAX)) begin
            r = ACC_MAX;
        end else if (x < 80'(ACC_MIN)) begin
            r = ACC_MIN;
        end else begin
            r = x[47:0];
        end
        return r;
    endfunction

    // Saturating 48-bit add
    function automatic acc_t add48(input acc_t a, input acc_t b);
        logic signed [48:0] s;
        acc_t r;
        s = 49'(a) + 49'(b);
        if (s[48] != s[47]) begin
            r = s[48] ? ACC_MIN : ACC_MAX;
        end else begin
            r = s[47:0];
        end
        return r;
    endfunction

endpackage

/* design/solid_element_stiffness_btcb.sv */
// Node pair stiffness block alpha*Bt*C*B. Load items are popped as soon as the engine is idle.
// A valid node pair runs 99 products on one shared 48x32 multiplier, each through split
// multiply, normalize and accumulate, with a C read before each of the 54 column dot
// products, and then emits nine result beats. A bad pair raises a single result with
// status and last set once the output register is free. Queue of two items.
// Reset: aresetn synchronous, active low; clears control and config (alpha 1.0, 4 nodes).
// Stores are undefined until written. Depends on sesb_pkg, sesb_front, sesb_fifo, sesb_back.
module solid_element_stiffness_btcb import sesb_pkg::*; #(
    parameter int MAX_NODES   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // slot, row_node, value_a, value_b, value_c, dof_x, dof_y, dof_z
    input  logic [127:0] s_tdata,
    // func
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // row_pos, col_pos, increment, zero fill
    output logic [63:0]  m_tdata,
    // status
    output logic         m_tuser,
    output logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_wdata
);

    q_item_t     push;
    q_item_t     head;
    logic        q_full;
    logic        pop;
    logic [31:0] scale_factor;

    sesb_front #(.MAX_NODES(MAX_NODES)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .q_full       (q_full),
        .push         (push),
        .scale_factor (scale_factor)
    );

    sesb_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .full    (q_full),
        .head    (head)
    );

    sesb_back #(.MAX_NODES(MAX_NODES), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .pop          (pop),
        .scale_factor (scale_factor),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule

/* design/sesb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sesb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/sesb_front.sv */
// Front end: input handshake, configuration registers and item classification.
// Depends on sesb_pkg.
module sesb_front import sesb_pkg::*; #(
    parameter int MAX_NODES = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // slot, row_node, value_a, value_b, value_c, dof_x, dof_y, dof_z
    input  logic [127:0]  s_tdata,
    // func
    input  logic [1:0]    s_tuser,
    input  logic          cfg_wr_en,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_wdata,
    input  logic          q_full,
    output q_item_t       push,
    output logic [31:0]   scale_factor
);

    logic [31:0] scale_reg;
    logic [5:0]  nodes_reg;
    logic [6:0]  lim;
    logic [6:0]  max_nodes;
    logic [6:0]  slot7;
    logic [6:0]  row7;
    logic        accept;
    cmd_t        cmd;
    logic        keep;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= 32'd65536;
            nodes_reg <= 6'd4;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_SCALE) begin
                scale_reg <= cfg_wdata;
            end else begin
                nodes_reg <= cfg_wdata[5:0];
            end
        end
    end

    assign scale_factor = scale_reg;

    // Field unpacking
    always_comb begin
        cmd.kind    = CMD_BAD;
        cmd.slot    = s_tdata[5:0];
        cmd.row     = s_tdata[10:6];
        cmd.value_a = s_tdata[42:11];
        cmd.value_b = s_tdata[74:43];
        cmd.value_c = s_tdata[106:75];
        cmd.dof_x   = s_tdata[113:107];
        cmd.dof_y   = s_tdata[120:114];
        cmd.dof_z   = s_tdata[127:121];
        keep        = 1'b0;

        max_nodes = 7'(MAX_NODES);
        lim       = ({1'b0, nodes_reg} < max_nodes) ? {1'b0, nodes_reg} : max_nodes;
        slot7     = {1'b0, s_tdata[5:0]};
        row7      = {2'b00, s_tdata[10:6]};

        // Classify: out-of-range loads and unknown kinds are dropped
        case (s_tuser)
            FUNC_LOAD_C: begin
                cmd.kind = CMD_LOAD_C;
                keep     = (slot7 < 7'(C_ENTRIES));
            end
            FUNC_LOAD_NODE: begin
                cmd.kind = CMD_LOAD_NODE;
                keep     = (slot7 < max_nodes);
            end
            FUNC_PAIR: begin
                keep     = 1'b1;
                cmd.kind = (slot7 < lim && row7 < lim && row7 >= slot7) ? CMD_PAIR : CMD_BAD;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready   = !q_full;
    assign accept     = s_tvalid && !q_full;
    assign push.valid = accept && keep;
    assign push.cmd   = cmd;

endmodule

/* design/sesb_fifo.sv */
// Two-entry command queue between the front end and the compute engine.
// Depends on sesb_pkg.
module sesb_fifo import sesb_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  q_item_t push,
    input  logic    pop,
    output logic    full,
    output q_item_t head
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign do_pop = pop && (count_reg != 2'd0);

    // Pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push.valid;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(push.valid) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entry_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

endmodule

/* design/sesb_back.sv */
// Compute engine: stores, node pair sequencer with one shared multiply-accumulate
// unit, and the result register. Depends on sesb_pkg and sesb_ram.
module sesb_back import sesb_pkg::*; #(
    parameter int MAX_NODES   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  q_item_t       head,
    output logic          pop,
    input  logic [31:0]   scale_factor,
    output logic          m_tvalid,
    input  logic          m_tready,
    // row_pos, col_pos, increment, zero fill
    output logic [63:0]   m_tdata,
    // status
    output logic          m_tuser,
    output logic          m_tlast
);

    localparam int SW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int NW = $clog2(MAX_NODES);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_RDJ    = 9'b000000010,
        ST_RDI    = 9'b000000100,
        ST_FETCH  = 9'b000001000,
        ST_MUL_LO = 9'b000010000,
        ST_MUL_HI = 9'b000100000,
        ST_NORM   = 9'b001000000,
        ST_ACC    = 9'b010000000,
        ST_EMIT   = 9'b100000000
    } state_t;

    typedef enum logic [2:0] {
        PH_COL_DOT   = 3'b001,
        PH_COL_SCALE = 3'b010,
        PH_ROW_DOT   = 3'b100
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [2:0] a_reg, a_next;
    logic [1:0] c_reg, c_next;
    logic [1:0] k_reg, k_next;
    logic [3:0] n_reg, n_next;
    logic       out_valid_reg, out_valid_next;

    logic [NW-1:0] i_reg;
    logic signed [SW-1:0] gj_reg [3];
    logic signed [SW-1:0] gi_reg [3];
    logic [6:0] dofj_reg [3];
    logic [6:0] dofi_reg [3];
    acc_t       acc_reg;
    acc_t       cval_reg [CVAL_ENTRIES];
    acc_t       prod_reg;
    logic signed [23:0] ah_reg;
    logic signed [31:0] b_reg;
    logic signed [56:0] pl_reg;
    logic signed [55:0] ph_reg;
    logic [6:0] out_row_reg;
    logic [6:0] out_col_reg;
    acc_t       out_inc_reg;
    logic       out_status_reg;
    logic       out_last_reg;

    logic       out_free;
    logic       out_load;
    logic       out_bad;

    // Store ports
    logic [NW-1:0]   slot_idx;
    logic [NW-1:0]   node_raddr;
    logic            c_we;
    logic            node_we;
    logic [5:0]      c_raddr;
    logic [SW-1:0]   c_rdata;
    logic [3*SW-1:0] grad_wdata;
    logic [3*SW-1:0] grad_rdata;
    logic [20:0]     dof_wdata;
    logic [20:0]     dof_rdata;

    // Datapath
    logic signed [SW-1:0] c_val;
    logic signed [47:0]   op_a;
    logic signed [31:0]   op_b;
    logic signed [24:0]   al_s;
    logic signed [56:0]   pl_prod;
    logic signed [55:0]   ph_prod;
    logic signed [79:0]   full_prod;
    logic [4:0]           cval_widx;
    logic [4:0]           cval_ridx;
    logic [1:0]           pr;
    logic [1:0]           pc;

    assign out_free = !out_valid_reg || m_tready;
    assign slot_idx = head.cmd.slot[NW-1:0];
    assign node_raddr = (state_reg == ST_IDLE) ? slot_idx : i_reg;
    assign c_we = (state_reg == ST_IDLE) && head.valid && (head.cmd.kind == CMD_LOAD_C);
    assign node_we = (state_reg == ST_IDLE) && head.valid && (head.cmd.kind == CMD_LOAD_NODE);
    assign c_raddr = 6'(a_reg) * 6'd6 + 6'(strain_of(c_reg, k_reg));
    assign grad_wdata = {head.cmd.value_c[SW-1:0], head.cmd.value_b[SW-1:0],
                         head.cmd.value_a[SW-1:0]};
    assign dof_wdata = {head.cmd.dof_z, head.cmd.dof_y, head.cmd.dof_x};

    sesb_ram #(.WIDTH(SW), .DEPTH(C_ENTRIES)) u_c_ram (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (head.cmd.slot),
        .wdata (head.cmd.value_a[SW-1:0]),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    sesb_ram #(.WIDTH(3*SW), .DEPTH(MAX_NODES)) u_grad_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (slot_idx),
        .wdata (grad_wdata),
        .raddr (node_raddr),
        .rdata (grad_rdata)
    );

    sesb_ram #(.WIDTH(21), .DEPTH(MAX_NODES)) u_dof_ram (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (slot_idx),
        .wdata (dof_wdata),
        .raddr (node_raddr),
        .rdata (dof_rdata)
    );

    // Operand select for the shared multiplier
    always_comb begin
        c_val     = c_rdata;
        pr        = pair_row(n_reg);
        pc        = pair_col(n_reg);
        cval_widx = 5'(a_reg) * 5'd3 + 5'(c_reg);
        cval_ridx = 5'(strain_of(pr, k_reg)) * 5'd3 + 5'(pc);
        case (phase_reg)
            PH_COL_DOT: begin
                op_a = 48'(c_val);
                op_b = 32'(gj_reg[k_reg]);
            end
            PH_COL_SCALE: begin
                op_a = acc_reg;
                op_b = scale_factor;
            end
            PH_ROW_DOT: begin
                op_a = cval_reg[cval_ridx];
                op_b = 32'(gi_reg[k_reg]);
            end
            default: begin
                op_a = acc_reg;
                op_b = scale_factor;
            end
        endcase
        // Split 48x32 product: unsigned low half now, signed high half next cycle
        al_s      = $signed({1'b0, op_a[23:0]});
        pl_prod   = al_s * op_b;
        ph_prod   = ah_reg * b_reg;
        full_prod = (80'(ph_reg) <<< 24) + 80'(pl_reg);
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        a_next         = a_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg && !m_tready;
        pop            = 1'b0;
        out_load       = 1'b0;
        out_bad        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    case (head.cmd.kind)
                        CMD_PAIR: begin
                            pop        = 1'b1;
                            state_next = ST_RDJ;
                        end
                        CMD_BAD: begin
                            if (out_free) begin
                                pop      = 1'b1;
                                out_load = 1'b1;
                                out_bad  = 1'b1;
                            end
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RDJ: begin
                state_next = ST_RDI;
            end
            ST_RDI: begin
                state_next = ST_FETCH;
                phase_next = PH_COL_DOT;
                a_next     = 3'd0;
                c_next     = 2'd0;
                k_next     = 2'd0;
                n_next     = 4'd0;
            end
            ST_FETCH: begin
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                state_next = ST_NORM;
            end
            ST_NORM: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                case (phase_reg)
                    PH_COL_DOT: begin
                        if (k_reg == 2'd2) begin
                            k_next     = 2'd0;
                            phase_next = PH_COL_SCALE;
                            state_next = ST_MUL_LO;
                        end else begin
                            k_next     = k_reg + 2'd1;
                            state_next = ST_FETCH;
                        end
                    end
                    PH_COL_SCALE: begin
                        if (c_reg == 2'd2) begin
                            c_next = 2'd0;
                            a_next = a_reg + 3'd1;
                        end else begin
                            c_next = c_reg + 2'd1;
                        end
                        if (a_reg == 3'd5 && c_reg == 2'd2) begin
                            a_next     = 3'd0;
                            phase_next = PH_ROW_DOT;
                            n_next     = 4'd0;
                            state_next = ST_MUL_LO;
                        end else begin
                            phase_next = PH_COL_DOT;
                            state_next = ST_FETCH;
                        end
                    end
                    default: begin
                        if (k_reg == 2'd2) begin
                            k_next     = 2'd0;
                            state_next = ST_EMIT;
                        end else begin
                            k_next     = k_reg + 2'd1;
                            state_next = ST_MUL_LO;
                        end
                    end
                endcase
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (n_reg == 4'd8) begin
                        state_next = ST_IDLE;
                    end else begin
                        n_next     = n_reg + 4'd1;
                        state_next = ST_MUL_LO;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (out_load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_COL_DOT;
            a_reg         <= 3'd0;
            c_reg         <= 2'd0;
            k_reg         <= 2'd0;
            n_reg         <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            a_reg         <= a_next;
            c_reg         <= c_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && head.valid && head.cmd.kind == CMD_PAIR) begin
            i_reg <= 7'({2'b00, head.cmd.row}) >= 7'(MAX_NODES) ? '0
                   : NW'({2'b00, head.cmd.row});
        end
        if (state_reg == ST_RDJ) begin
            gj_reg[0]   <= grad_rdata[SW-1:0];
            gj_reg[1]   <= grad_rdata[2*SW-1:SW];
            gj_reg[2]   <= grad_rdata[3*SW-1:2*SW];
            dofj_reg[0] <= dof_rdata[6:0];
            dofj_reg[1] <= dof_rdata[13:7];
            dofj_reg[2] <= dof_rdata[20:14];
        end
        if (state_reg == ST_RDI) begin
            gi_reg[0]   <= grad_rdata[SW-1:0];
            gi_reg[1]   <= grad_rdata[2*SW-1:SW];
            gi_reg[2]   <= grad_rdata[3*SW-1:2*SW];
            dofi_reg[0] <= dof_rdata[6:0];
            dofi_reg[1] <= dof_rdata[13:7];
            dofi_reg[2] <= dof_rdata[20:14];
            acc_reg     <= '0;
        end
        if (state_reg == ST_MUL_LO) begin
            ah_reg <= op_a[47:24];
            b_reg  <= op_b;
            pl_reg <= pl_prod;
        end
        if (state_reg == ST_MUL_HI) begin
            ph_reg <= ph_prod;
        end
        if (state_reg == ST_NORM) begin
            prod_reg <= sat48(full_prod >>> 16);
        end
        if (state_reg == ST_ACC) begin
            if (phase_reg == PH_COL_SCALE) begin
                cval_reg[cval_widx] <= prod_reg;
                acc_reg             <= '0;
            end else begin
                acc_reg <= add48(acc_reg, prod_reg);
            end
        end
        if (state_reg == ST_EMIT && out_free) begin
            acc_reg <= '0;
        end
        if (out_load) begin
            out_row_reg    <= out_bad ? 7'd0 : dofi_reg[pr];
            out_col_reg    <= out_bad ? 7'd0 : dofj_reg[pc];
            out_inc_reg    <= out_bad ? '0 : acc_reg;
            out_status_reg <= out_bad;
            out_last_reg   <= out_bad || (n_reg == 4'd8);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_inc_reg, out_col_reg, out_row_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    ap_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg |-> out_last_reg)
        else $error("error result without last");

    ap_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg |-> m_tdata == 64'd0)
        else $error("error result carries data");

    ap_counters: assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg != 2'd3 && n_reg <= 4'd8 && a_reg <= 3'd5 && c_reg != 2'd3)
        else $error("sequencer counter out of range");

    ap_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid && state_reg == ST_IDLE)
        else $error("queue popped while empty or busy");
`endif

endmodule

/* dv/solid_element_stiffness_btcb_tb.sv */
// Testbench for solid_element_stiffness_btcb: a directed table, then random load, pair and spare items.
// Results are checked field by field against a local Q16.16 saturating model of alpha*Bt*C*B.
// Depends on sesb_pkg and the block's RTL only.
`timescale 1ns / 1ps

module solid_element_stiffness_btcb_tb;
    import sesb_pkg::*;

    localparam int NODES = 32;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    typedef struct packed {
        logic [6:0]  row_pos;
        logic [6:0]  col_pos;
        logic [47:0] increment;
        logic        status;
        logic        last;
    } beat_t;

    typedef struct {
        logic [1:0]  func;
        logic [5:0]  slot;
        logic [4:0]  row;
        logic [31:0] va;
        logic [31:0] vb;
        logic [31:0] vc;
        logic [6:0]  dx;
        logic [6:0]  dy;
        logic [6:0]  dz;
        bit          typed;
        beat_t       typed_beat;
    } stim_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_index = 1'b0;
    logic [31:0]  cfg_wdata = '0;

    // model state
    acc_t        c_mat [36];
    acc_t        g_mat [NODES][3];
    logic [6:0]  dof_tab [NODES][3];
    bit          node_set [NODES];
    acc_t        alpha;
    int unsigned n_nodes;

    beat_t       expected_beats [$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          recv_hold = 1'b0;
    stim_t       directed [$];

    solid_element_stiffness_btcb u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Q16.16 product, floor shift, clamp to 48 bits
    function automatic acc_t qmul(input acc_t a, input acc_t b);
        logic signed [95:0] p;
        p = 96'(a) * 96'(b);
        p = p >>> 16;
        if (p > 96'(ACC_MAX)) return ACC_MAX;
        if (p < 96'(ACC_MIN)) return ACC_MIN;
        return p[47:0];
    endfunction

    function automatic acc_t qadd(input acc_t a, input acc_t b);
        logic signed [48:0] s;
        s = 49'(a) + 49'(b);
        if (s > 49'(ACC_MAX)) return ACC_MAX;
        if (s < 49'(ACC_MIN)) return ACC_MIN;
        return s[47:0];
    endfunction

    function automatic int strain_idx(input int r, input int c);
        int t [3][3] = '{'{0, 3, 5}, '{3, 1, 4}, '{5, 4, 2}};
        return t[r][c];
    endfunction

    // Update the model for one accepted item and queue its results
    task automatic predict_stiffness(input stim_t s);
        acc_t  colterm [6][3];
        acc_t  acc;
        int    ri [9] = '{0, 1, 2, 0, 1, 0, 2, 1, 2};
        int    ci [9] = '{0, 1, 2, 1, 0, 2, 0, 2, 1};
        int    j;
        int    i;
        beat_t b;
        j = s.slot;
        i = s.row;
        case (s.func)
            FUNC_LOAD_C: if (s.slot < 36) c_mat[s.slot] = 48'(signed'(s.va));
            FUNC_LOAD_NODE: if (s.slot < NODES) begin
                g_mat[j] = '{48'(signed'(s.va)), 48'(signed'(s.vb)), 48'(signed'(s.vc))};
                dof_tab[j] = '{s.dx, s.dy, s.dz};
                node_set[j] = 1'b1;
            end
            FUNC_PAIR: begin
                if (j >= n_nodes || i >= n_nodes || i < j) begin
                    b = '{7'd0, 7'd0, 48'd0, 1'b1, 1'b1};
                    expected_beats.push_back(b);
                end else begin
                    for (int a = 0; a < 6; a++) begin
                        for (int c = 0; c < 3; c++) begin
                            acc = '0;
                            for (int k = 0; k < 3; k++)
                                acc = qadd(acc, qmul(c_mat[a*6 + strain_idx(c, k)], g_mat[j][k]));
                            colterm[a][c] = qmul(acc, alpha);
                        end
                    end
                    for (int n = 0; n < 9; n++) begin
                        acc = '0;
                        for (int k = 0; k < 3; k++)
                            acc = qadd(acc, qmul(g_mat[i][k], colterm[strain_idx(ri[n], k)][ci[n]]));
                        b = '{dof_tab[i][ri[n]], dof_tab[j][ci[n]], acc, 1'b0, n == 8};
                        expected_beats.push_back(b);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // Receiver: random stall, long hold on request
    always @(posedge aclk) begin
        if (!aresetn || recv_hold) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker and watchdog
    always @(posedge aclk) begin
        beat_t got;
        beat_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("solid_element_stiffness_btcb_tb failed");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[6:0], m_tdata[13:7], m_tdata[61:14], m_tuser, m_tlast};
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected result", 64'(got), 64'd0);
                end else begin
                    want = expected_beats.pop_front();
                    if (got.row_pos != want.row_pos)
                        report_mismatch("row_pos", 64'(got.row_pos), 64'(want.row_pos));
                    if (got.col_pos != want.col_pos)
                        report_mismatch("col_pos", 64'(got.col_pos), 64'(want.col_pos));
                    if (got.increment != want.increment)
                        report_mismatch("increment", 64'(got.increment), 64'(want.increment));
                    if (got.status != want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.last != want.last)
                        report_mismatch("last", 64'(got.last), 64'(want.last));
                end
            end
        end
    end

    // Offer one item and wait for acceptance; predict on acceptance.
    // tvalid stays high after acceptance until the caller idles or offers the next item.
    task automatic send_item(input stim_t s);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= s.func;
        s_tdata  <= {7'd0, s.dz, s.dy, s.dx, s.vc, s.vb, s.va, s.row, s.slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (s.typed) expected_beats.push_back(s.typed_beat);
        else predict_stiffness(s);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (500) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_SCALE) alpha = 48'(signed'(v));
        else n_nodes = (v[5:0] < NODES) ? v[5:0] : NODES;
    endtask

    function automatic stim_t mk(input logic [1:0] f, input int sl, input int rw,
                                 input logic [31:0] a, input logic [31:0] b,
                                 input logic [31:0] c, input int x, input int y, input int z);
        stim_t s;
        s = '{f, 6'(sl), 5'(rw), a, b, c, 7'(x), 7'(y), 7'(z), 1'b0, '0};
        return s;
    endfunction

    function automatic stim_t bad_pair(input int j, input int i);
        stim_t s;
        s = mk(FUNC_PAIR, j, i, $urandom, $urandom, $urandom, 0, 0, 0);
        s.typed = 1'b1;
        s.typed_beat = '{7'd0, 7'd0, 48'd0, 1'b1, 1'b1};
        return s;
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'(signed'($urandom_range(0, 1 << 19)) - (1 << 18));
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'(signed'($urandom_range(0, 1 << 17)) - (1 << 16));
        endcase
    endfunction

    function automatic stim_t rand_node(input int n);
        return mk(FUNC_LOAD_NODE, n, $urandom, rand_q(), rand_q(), rand_q(),
                  $urandom_range(127), $urandom_range(127), $urandom_range(127));
    endfunction

    // Random pair; valid pairs need both nodes loaded
    function automatic stim_t rand_pair();
        int j;
        int i;
        if ($urandom_range(9) == 0) begin
            j = $urandom_range(63);
            i = $urandom_range(31);
            if (!(j >= n_nodes || i >= n_nodes || i < j)) j = 63;
            return mk(FUNC_PAIR, j, i, $urandom, $urandom, $urandom,
                      $urandom_range(127), $urandom_range(127), $urandom_range(127));
        end
        j = $urandom_range(n_nodes - 1);
        i = $urandom_range(n_nodes - 1, j);
        return mk(FUNC_PAIR, j, i, $urandom, $urandom, $urandom,
                  $urandom_range(127), $urandom_range(127), $urandom_range(127));
    endfunction

    initial begin
        stim_t s;
        int sent;
        int phase_len;
        alpha = 48'sd65536;
        n_nodes = 4;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: bad pairs after reset, full C, extreme and out-of-range loads, a spare item, every pair kind
        directed.push_back(bad_pair(1, 0));
        directed.push_back(bad_pair(4, 4));
        directed.push_back(bad_pair(0, 31));
        directed.push_back(bad_pair(63, 0));
        for (int k = 0; k < 36; k++)
            directed.push_back(mk(FUNC_LOAD_C, k, 0, (k % 7 == 0) ? 32'h0001_0000 : rand_q(),
                                  0, 0, 0, 0, 0));
        directed.push_back(mk(FUNC_LOAD_C, 63, 31, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
        directed.push_back(mk(FUNC_LOAD_NODE, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                              0, 95, 127));
        directed.push_back(mk(FUNC_LOAD_NODE, 1, 31, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0,
                              127, 0, 1));
        directed.push_back(rand_node(2));
        directed.push_back(rand_node(3));
        directed.push_back(mk(FUNC_LOAD_NODE, 40, 0, 32'h1, 32'h1, 32'h1, 1, 1, 1));
        directed.push_back(mk(FUNC_SPARE, 0, 0, 32'h1, 32'h1, 32'h1, 1, 1, 1));
        directed.push_back(mk(FUNC_PAIR, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(FUNC_PAIR, 0, 3, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(FUNC_PAIR, 1, 1, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(FUNC_PAIR, 2, 3, 0, 0, 0, 0, 0, 0));
        foreach (directed[k]) send_item(directed[k]);
        drain_results();

        // Load every node so any pair within node_count is defined
        for (int n = 0; n < NODES; n++) send_item(rand_node(n));
        drain_results();

        // Configuration sweep with varied idling
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_SCALE, 32'h7FFF_FFFF); write_reg(CFG_NODES, 32'd32); end
                1: begin write_reg(CFG_SCALE, 32'h8000_0000); write_reg(CFG_NODES, 32'd1); end
                2: begin write_reg(CFG_SCALE, $urandom); write_reg(CFG_NODES, 32'd63); end
                3: begin write_reg(CFG_SCALE, 32'h0000_8000); write_reg(CFG_NODES, 32'd5); end
                4: begin write_reg(CFG_SCALE, 32'hFFFF_0000); write_reg(CFG_NODES, 32'd32); end
                default: begin write_reg(CFG_SCALE, 32'h0001_0000); write_reg(CFG_NODES, 32'd8); end
            endcase
            send_idle_pct = (ph < 2) ? 28 : (ph < 4) ? 86 : 0;
            recv_idle_pct = (ph < 2) ? 86 : (ph < 4) ? 28 : 0;
            phase_len = 65;
            for (sent = 0; sent < phase_len; sent++) begin
                case ($urandom_range(9))
                    0: s = mk(FUNC_LOAD_C, $urandom_range(63), $urandom, rand_q(), $urandom,
                              $urandom, $urandom, $urandom, $urandom);
                    1: s = rand_node($urandom_range(63) < 40 ? $urandom_range(31) : 33);
                    2: s = mk(FUNC_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom);
                    default: s = rand_pair();
                endcase
                send_item(s);
                // long receiver hold while items keep coming
                if (ph == 4 && sent == 10) begin
                    fork
                        begin
                            recv_hold = 1'b1;
                            repeat (3000) @(posedge aclk);
                            recv_hold = 1'b0;
                        end
                    join_none
                end
                // sender waits for every expected result
                if (sent == 35) begin
                    s_tvalid <= 1'b0;
                    while (expected_beats.size() != 0) @(posedge aclk);
                end
            end
            drain_results();
        end

        if (errors == 0) begin
            $display("solid_element_stiffness_btcb_tb passed");
        end else begin
            $display("solid_element_stiffness_btcb_tb failed");
        end
        $finish;
    end

endmodule

/* files.f */
design/sesb_pkg.sv
design/sesb_ram.sv
design/sesb_front.sv
design/sesb_fifo.sv
design/sesb_back.sv
design/solid_element_stiffness_btcb.sv
dv/solid_element_stiffness_btcb_tb.sv
